// ===== rtl/core/spifw_pkg.sv =====
`timescale 1ns / 1ps

package spifw_pkg;

  localparam logic [31:0] FW_BYTES = 32'd262144;
  localparam int          FW_AW    = $clog2(FW_BYTES);
  localparam int          QDEPTH   = 2;
  localparam int          QPTR_W   = $clog2(QDEPTH);

  localparam logic [1:0]  OP_CTRL  = 2'd0;
  localparam logic [1:0]  OP_DATA  = 2'd1;
  localparam logic [1:0]  OP_LOAD  = 2'd2;

  localparam logic [1:0]  DEV_FW    = 2'd1;
  localparam logic [1:0]  DEV_TOUCH = 2'd2;

  localparam logic [2:0]  CH_TOUCH_Y = 3'd1;
  localparam logic [2:0]  CH_TOUCH_X = 3'd5;
  localparam logic [2:0]  CH_MIC     = 3'd6;

  localparam logic [7:0]  CMD_READ   = 8'h03;
  localparam logic [15:0] CTRL_WMASK = 16'hCF03;
  localparam logic [11:0] MIC_OFFSET = 12'h800;

  localparam int CTRL_STEP2 = 10;
  localparam int CTRL_HOLD  = 11;
  localparam int CTRL_IRQEN = 14;
  localparam int CTRL_EN    = 15;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_FW_CMD     = 2'd1,
    ERR_TOUCH_CHAN = 2'd2,
    ERR_DEVICE     = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } act_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        value;
    logic [15:0]        mask;
    logic [17:0]        load_address;
    logic [11:0]        touch_x;
    logic [11:0]        touch_y;
    logic signed [15:0] mic_raw;
    logic               mic_present;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  spi_data;
    logic        irq;
    logic [15:0] control_readback;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    act_t             act;
    logic [FW_AW-1:0] addr;
    logic [7:0]       wdata;
    out_item_t        res;
  } desc_t;

endpackage

// ===== rtl/core/spi_firmware_touch_mic_port_core.sv =====
// an accepted transaction is written into the queue, then popped into the back-end result register and shown on out_*
// throughput: one transaction per cycle while out_stall is low, set by the single firmware store port in the back end
// the front end stalls only when the two-entry queue is full
// reset: control word, byte counter, command, address, mic sample and held data byte clear to zero
// the firmware store is not cleared; entries hold nothing until loaded
`timescale 1ns / 1ps

module spi_firmware_touch_mic_port_core
  import spifw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic             accept;
  desc_t            front_desc;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  desc_t            q_head;
  logic [FW_AW-1:0] ram_addr;
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  spifw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .desc   (front_desc)
  );

  spifw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_desc (front_desc),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  spifw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_addr  (ram_addr),
    .ram_we    (ram_we),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  spifw_ram #(
    .WIDTH (8),
    .DEPTH (int'(FW_BYTES))
  ) u_fw_store (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/spifw_ram.sv =====
`timescale 1ns / 1ps

module spifw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/spifw_front.sv =====
`timescale 1ns / 1ps

module spifw_front
  import spifw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output desc_t    desc
);

  logic [15:0] ctrl_r, ctrl_nxt;
  logic [31:0] bc_r, bc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [31:0] fa_r, fa_nxt;
  logic [11:0] mic_r, mic_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [15:0] msk;
  logic [1:0]  dev;
  logic [2:0]  chan;
  logic [11:0] tv;
  logic [11:0] mic_conv;
  logic [7:0]  b;
  logic [4:0]  sh;
  logic [7:0]  data;
  err_t        err;

  always_comb begin
    ctrl_nxt = ctrl_r;
    bc_nxt   = bc_r;
    cmd_nxt  = cmd_r;
    fa_nxt   = fa_r;
    mic_nxt  = mic_r;
    held_nxt = held_r;
    desc       = '0;
    desc.act   = ACT_NONE;
    data       = '0;
    err        = ERR_OK;
    msk        = item.mask & CTRL_WMASK;
    dev        = ctrl_r[9:8];
    chan       = cmd_r[6:4];
    b          = item.value[7:0];
    sh         = {2'd3 - bc_r[1:0], 3'b000};
    tv         = (chan == CH_TOUCH_Y) ? item.touch_y : item.touch_x;
    mic_conv   = item.mic_present ? (item.mic_raw[15:4] ^ MIC_OFFSET) : '0;
    desc.wdata = item.value[7:0];

    unique case (item.operation)
      OP_CTRL: begin
        ctrl_nxt = (ctrl_r & ~msk) | (item.value & msk);
      end
      OP_LOAD: begin
        if (32'(item.load_address) < FW_BYTES) begin
          desc.act  = ACT_WRITE;
          desc.addr = item.load_address[FW_AW-1:0];
        end
      end
      OP_DATA: begin
        if (ctrl_r[CTRL_EN]) begin
          if (bc_r == '0) begin
            cmd_nxt = b;
            fa_nxt  = '0;
          end else begin
            unique case (dev)
              DEV_FW: begin
                if (cmd_r != CMD_READ) begin
                  err = ERR_FW_CMD;
                end else if (bc_r < 32'd4) begin
                  // address phase, msb first
                  fa_nxt = fa_r | (32'(b) << sh);
                  data   = held_r;
                end else begin
                  if (fa_r < FW_BYTES) begin
                    desc.act  = ACT_READ;
                    desc.addr = fa_r[FW_AW-1:0];
                  end
                  fa_nxt = fa_r + (ctrl_r[CTRL_STEP2] ? 32'd2 : 32'd1);
                end
              end
              DEV_TOUCH: begin
                unique case (chan) inside
                  CH_TOUCH_Y, CH_TOUCH_X: begin
                    data = bc_r[0] ? {1'b0, tv[11:5]} : {tv[4:0], 3'b000};
                  end
                  CH_MIC: begin
                    if (bc_r[0]) begin
                      mic_nxt = mic_conv;
                      data    = {1'b0, mic_conv[11:5]};
                    end else begin
                      data = {mic_r[4:0], 3'b000};
                    end
                  end
                  default: err = ERR_TOUCH_CHAN;
                endcase
              end
              default: err = ERR_DEVICE;
            endcase
          end
          held_nxt     = data;
          bc_nxt       = ctrl_r[CTRL_HOLD] ? bc_r + 32'd1 : '0;
          desc.res.irq = ctrl_r[CTRL_IRQEN];
        end else begin
          held_nxt = '0;
        end
      end
      default: ;
    endcase

    desc.res.spi_data         = data;
    desc.res.error_code       = err;
    desc.res.control_readback = ctrl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      bc_r   <= '0;
      cmd_r  <= '0;
      fa_r   <= '0;
      mic_r  <= '0;
      held_r <= '0;
    end else if (accept) begin
      ctrl_r <= ctrl_nxt;
      bc_r   <= bc_nxt;
      cmd_r  <= cmd_nxt;
      fa_r   <= fa_nxt;
      mic_r  <= mic_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/core/spifw_queue.sv =====
`timescale 1ns / 1ps

module spifw_queue
  import spifw_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output desc_t head
);

  desc_t                slot_r [QDEPTH];
  logic [QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [QPTR_W:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/spifw_back.sv =====
`timescale 1ns / 1ps

module spifw_back
  import spifw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  desc_t            q_head,
  output logic             q_pop,
  output logic [FW_AW-1:0] ram_addr,
  output logic             ram_we,
  output logic [7:0]       ram_wdata,
  output logic             ram_re,
  input  logic [7:0]       ram_rdata,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  logic      out_valid_r, out_valid_nxt;
  logic      sel_mem_r;
  out_item_t res_r;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign ram_addr  = q_head.addr;
  assign ram_wdata = q_head.wdata;
  assign ram_we    = q_pop && (q_head.act == ACT_WRITE);
  assign ram_re    = q_pop && (q_head.act == ACT_READ);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r     <= q_head.res;
      sel_mem_r <= (q_head.act == ACT_READ);
    end
  end

  // read data stays put while the transaction is stalled
  always_comb begin
    out_data = res_r;
    if (sel_mem_r) begin
      out_data.spi_data = ram_rdata;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/spifw_checker.sv =====
`timescale 1ns / 1ps

module spifw_checker
  import spifw_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code != ERR_OK) |->
      (out_data.spi_data == 8'd0) && out_data.control_readback[CTRL_EN])
    else $error("error transaction with data or with port disabled");

  a_irq_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.irq |->
      out_data.control_readback[CTRL_EN] && out_data.control_readback[CTRL_IRQEN])
    else $error("irq without enable bits");

endmodule

bind spi_firmware_touch_mic_port_core spifw_checker u_spifw_checker (.*);

// ===== tb/spi_firmware_touch_mic_port_checker.sv =====
`timescale 1ns / 1ps

module spi_firmware_touch_mic_port_checker
  import spifw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);

  logic [15:0] ctrl_q;
  logic [31:0] count_q;
  logic [7:0]  cmd_q;
  logic [31:0] addr_q;
  logic [11:0] mic_q;
  logic [7:0]  held_q;
  logic [7:0]  fw_image [int unsigned];

  out_item_t responses_due [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic out_item_t port_response(input in_item_t it);
    out_item_t   r;
    logic [15:0] m;
    logic [7:0]  b;
    logic [7:0]  d;
    logic [2:0]  chan;
    logic [11:0] tv;
    r = '0;
    b = it.value[7:0];
    case (it.operation)
      OP_CTRL: begin
        m = it.mask & CTRL_WMASK;
        ctrl_q = (ctrl_q & ~m) | (it.value & m);
      end
      OP_LOAD: begin
        if ({14'b0, it.load_address} < FW_BYTES) fw_image[it.load_address] = b;
      end
      OP_DATA: begin
        if (ctrl_q[CTRL_EN]) begin
          d = 8'h00;
          if (count_q == 0) begin
            cmd_q  = b;
            addr_q = '0;
          end else if (ctrl_q[9:8] == DEV_FW) begin
            if (cmd_q != CMD_READ) begin
              r.error_code = ERR_FW_CMD;
            end else if (count_q < 4) begin
              addr_q = addr_q | ({24'b0, b} << ((32'd3 - count_q) * 8));
              d = held_q;
            end else begin
              if (addr_q < FW_BYTES && fw_image.exists(addr_q)) d = fw_image[addr_q];
              addr_q = addr_q + (ctrl_q[CTRL_STEP2] ? 32'd2 : 32'd1);
            end
          end else if (ctrl_q[9:8] == DEV_TOUCH) begin
            chan = cmd_q[6:4];
            if (chan == CH_TOUCH_Y || chan == CH_TOUCH_X) begin
              tv = (chan == CH_TOUCH_Y) ? it.touch_y : it.touch_x;
              d = count_q[0] ? {1'b0, tv[11:5]} : {tv[4:0], 3'b000};
            end else if (chan == CH_MIC) begin
              if (count_q[0]) begin
                mic_q = it.mic_present ? (it.mic_raw[15:4] ^ MIC_OFFSET) : 12'h000;
                d = {1'b0, mic_q[11:5]};
              end else begin
                d = {mic_q[4:0], 3'b000};
              end
            end else begin
              r.error_code = ERR_TOUCH_CHAN;
            end
          end else begin
            r.error_code = ERR_DEVICE;
          end
          held_q     = d;
          r.spi_data = d;
          count_q    = ctrl_q[CTRL_HOLD] ? count_q + 32'd1 : 32'd0;
          r.irq      = ctrl_q[CTRL_IRQEN];
        end else begin
          held_q = 8'h00;
        end
      end
      default: ;
    endcase
    r.control_readback = ctrl_q;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ctrl_q  = '0;
      count_q = '0;
      cmd_q   = '0;
      addr_q  = '0;
      mic_q   = '0;
      held_q  = '0;
      responses_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (responses_due.size() == 0) begin
          report_mismatch($sformatf("result with no transaction due, data %h", out_data));
        end else begin
          want = responses_due.pop_front();
          if (out_data.spi_data !== want.spi_data)
            report_mismatch($sformatf("spi_data got %h want %h",
                                      out_data.spi_data, want.spi_data));
          if (out_data.irq !== want.irq)
            report_mismatch($sformatf("irq got %b want %b", out_data.irq, want.irq));
          if (out_data.control_readback !== want.control_readback)
            report_mismatch($sformatf("control_readback got %h want %h",
                                      out_data.control_readback, want.control_readback));
          if (out_data.error_code !== want.error_code)
            report_mismatch($sformatf("error_code got %0d want %0d",
                                      out_data.error_code, want.error_code));
        end
      end
      if (in_valid && !in_stall) responses_due.push_back(port_response(in_data));
    end
    outstanding = responses_due.size();
  end

endmodule

// ===== tb/spi_firmware_touch_mic_port_core_tb.sv =====
`timescale 1ns / 1ps

module spi_firmware_touch_mic_port_core_tb;
  import spifw_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [15:0] C_EN         = 16'h1 << CTRL_EN;
  localparam logic [15:0] C_HOLD       = 16'h1 << CTRL_HOLD;
  localparam logic [15:0] C_IRQEN      = 16'h1 << CTRL_IRQEN;
  localparam logic [15:0] C_STEP2      = 16'h1 << CTRL_STEP2;
  localparam logic [15:0] C_FW         = 16'(DEV_FW) << 8;
  localparam logic [15:0] C_TOUCH      = 16'(DEV_TOUCH) << 8;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int unsigned LIMIT        = 1_500_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        mismatches;
  int        outstanding;

  int unsigned cycle_count = 0;
  int          sent_items  = 0;
  int          calm_left   = 0;

  // stimulus-side view of the addressing state, used to keep reads on loaded bytes
  logic [15:0] sh_ctrl;
  logic [31:0] sh_count;
  logic [7:0]  sh_cmd;
  logic [31:0] sh_addr;
  bit          loaded [0:FW_BYTES-1];

  spi_firmware_touch_mic_port_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  spi_firmware_touch_mic_port_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("spi_firmware_touch_mic_port_core_tb: done, errors");
    $finish;
  end

  initial begin
    int free_len;
    int stall_len;
    int r;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      free_len = (r < 5) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      r = $urandom_range(0, 99);
      if (r < 70)      stall_len = $urandom_range(0, 2);
      else if (r < 95) stall_len = $urandom_range(3, 8);
      else             stall_len = $urandom_range(20, 60);
      repeat (free_len) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    it.operation    = 2'($urandom_range(0, 3));
    it.value        = 16'($urandom);
    it.mask         = 16'($urandom);
    it.load_address = 18'($urandom);
    it.touch_x      = 12'($urandom);
    it.touch_y      = 12'($urandom);
    it.mic_raw      = 16'($urandom);
    it.mic_present  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void track(input in_item_t it);
    case (it.operation)
      OP_CTRL: sh_ctrl = (sh_ctrl & ~(it.mask & CTRL_WMASK)) | (it.value & it.mask & CTRL_WMASK);
      OP_LOAD: loaded[it.load_address] = 1'b1;
      OP_DATA: begin
        if (sh_ctrl[CTRL_EN]) begin
          if (sh_count == 0) begin
            sh_cmd  = it.value[7:0];
            sh_addr = '0;
          end else if (sh_ctrl[9:8] == DEV_FW && sh_cmd == CMD_READ) begin
            if (sh_count < 4)
              sh_addr = sh_addr | ({24'b0, it.value[7:0]} << ((32'd3 - sh_count) * 8));
            else
              sh_addr = sh_addr + (sh_ctrl[CTRL_STEP2] ? 32'd2 : 32'd1);
          end
          sh_count = sh_ctrl[CTRL_HOLD] ? sh_count + 32'd1 : 32'd0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    int r;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_items++;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        calm_left = $urandom_range(50, 150);
        gap = 0;
      end else if (r < 60) gap = 0;
      else if (r < 90)     gap = $urandom_range(1, 3);
      else if (r < 98)     gap = $urandom_range(4, 10);
      else                 gap = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // a flash read that would hit a byte never loaded gets that byte loaded first
  task automatic issue(input in_item_t it);
    in_item_t ld;
    if (it.operation == OP_DATA && sh_ctrl[CTRL_EN] && sh_ctrl[9:8] == DEV_FW &&
        sh_cmd == CMD_READ && sh_count >= 4 && sh_addr < FW_BYTES &&
        !loaded[sh_addr[FW_AW-1:0]]) begin
      ld = rand_item();
      ld.operation    = OP_LOAD;
      ld.load_address = sh_addr[FW_AW-1:0];
      send(ld);
      track(ld);
    end
    send(it);
    track(it);
  endtask

  task automatic ctrl_write(input logic [15:0] value, input logic [15:0] mask);
    in_item_t it;
    it = rand_item();
    it.operation = OP_CTRL;
    it.value     = value;
    it.mask      = mask;
    issue(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it = rand_item();
    it.operation   = OP_DATA;
    it.value[7:0]  = b;
    issue(it);
  endtask

  task automatic load_byte(input logic [17:0] addr, input logic [7:0] b);
    in_item_t it;
    it = rand_item();
    it.operation    = OP_LOAD;
    it.load_address = addr;
    it.value[7:0]   = b;
    issue(it);
  endtask

  // clear the byte counter with one byte while hold is off, then raise hold
  task automatic begin_transfer(input logic [15:0] ctrl);
    ctrl_write((ctrl & ~C_HOLD) | (16'($urandom) & ~CTRL_WMASK), 16'hFFFF);
    send_byte(8'($urandom));
    ctrl_write(16'($urandom) | C_HOLD, C_HOLD);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic mic_byte(input logic signed [15:0] raw, input logic present);
    in_item_t it;
    it = rand_item();
    it.operation   = OP_DATA;
    it.mic_raw     = raw;
    it.mic_present = present;
    issue(it);
  endtask

  function automatic logic [15:0] rand_ctrl(input logic [15:0] dev);
    return C_EN | dev | ($urandom_range(0, 1) ? C_IRQEN : 16'h0) |
           ($urandom_range(0, 1) ? C_STEP2 : 16'h0) | 16'($urandom_range(0, 3));
  endfunction

  task automatic flash_sequence();
    logic [31:0] addr;
    int          k;
    int          n;
    begin_transfer(rand_ctrl(C_FW));
    send_byte(($urandom_range(0, 99) < 85) ? CMD_READ : 8'($urandom));
    k = $urandom_range(0, 99);
    if (k < 60)      addr = $urandom_range(0, 63);
    else if (k < 80) addr = FW_BYTES - 1 - $urandom_range(0, 40);
    else if (k < 90) addr = $urandom_range(0, FW_BYTES - 1);
    else             addr = $urandom & 32'h00FF_FFFF;
    if ($urandom_range(0, 99) < 30) load_byte(18'(addr + $urandom_range(0, 8)), 8'($urandom));
    send_byte(addr[23:16]);
    send_byte(addr[15:8]);
    send_byte(addr[7:0]);
    n = $urandom_range(1, 10);
    repeat (n) begin
      if ($urandom_range(0, 99) < 8) load_byte(18'($urandom_range(0, 80)), 8'($urandom));
      send_byte(8'($urandom));
    end
  endtask

  task automatic touch_sequence();
    logic [2:0] chan;
    int         k;
    int         n;
    in_item_t   it;
    begin_transfer(rand_ctrl(C_TOUCH));
    k = $urandom_range(0, 99);
    if (k < 30)      chan = CH_TOUCH_Y;
    else if (k < 60) chan = CH_TOUCH_X;
    else if (k < 90) chan = CH_MIC;
    else             chan = 3'($urandom);
    send_byte({1'($urandom), chan, 4'($urandom)});
    n = $urandom_range(1, 8);
    repeat (n) begin
      it = rand_item();
      it.operation   = OP_DATA;
      it.mic_present = ($urandom_range(0, 99) < 75);
      issue(it);
    end
  endtask

  initial begin
    int base;
    int k;
    in_item_t it;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    sh_ctrl  = '0;
    sh_count = '0;
    sh_cmd   = '0;
    sh_addr  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    ctrl_write(16'hFFFF, 16'hFFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    it = rand_item();
    it.operation = OP_UNUSED;
    issue(it);
    load_byte(18'h00000, 8'hA5);
    load_byte(18'h3FFFF, 8'hFF);
    ctrl_write(16'h0000, 16'hFFFF);
    send_byte(8'hFF);
    begin_transfer(C_EN | C_IRQEN | C_STEP2 | C_FW);
    send_byte(CMD_READ);
    send_byte(8'h03);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    begin_transfer(C_EN | C_TOUCH);
    send_byte({1'b0, CH_MIC, 4'h0});
    mic_byte(16'sh8000, 1'b1);
    mic_byte(16'sh0000, 1'b1);
    mic_byte(16'sh7FFF, 1'b1);
    mic_byte(16'sh7FFF, 1'b0);
    wait_idle();

    base = sent_items;
    while (sent_items < base + RANDOM_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        flash_sequence();
      end else if (k < 70) begin
        touch_sequence();
      end else if (k < 80) begin
        repeat ($urandom_range(1, 6))
          load_byte(($urandom_range(0, 1)) ? 18'($urandom_range(0, 80)) : 18'($urandom),
                    8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) issue(rand_item());
      end
      if ($urandom_range(0, 99) < 3) wait_idle();
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("spi_firmware_touch_mic_port_core_tb: done, clean");
    else
      $display("spi_firmware_touch_mic_port_core_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/spifw_pkg.sv
rtl/core/spifw_ram.sv
rtl/core/spifw_front.sv
rtl/core/spifw_queue.sv
rtl/core/spifw_back.sv
rtl/core/spi_firmware_touch_mic_port_core.sv
rtl/core/spifw_checker.sv
tb/spi_firmware_touch_mic_port_checker.sv
tb/spi_firmware_touch_mic_port_core_tb.sv
